@@ hw/rtl/a2b_pkg.sv @@
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants for the binary-angle atan2 pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package a2b_pkg;

  localparam int unsigned CompW  = 16;            // vector component width
  localparam int unsigned AngW   = 16;            // heading width
  localparam int unsigned RatioSh = 14;           // Q14 ratio
  localparam int unsigned TW     = RatioSh + 1;   // t spans 0..16384
  localparam int unsigned RemW   = CompW + 1;     // partial remainder
  localparam int unsigned DiffW  = 14;
  localparam int unsigned CorrW  = 12;
  localparam int unsigned GainW  = 14;

  localparam logic [TW-1:0]    KneePoint  = TW'(16'h1333);
  localparam logic [CorrW-1:0] SlopeCorr  = CorrW'(16'h0B00);
  localparam logic [GainW-1:0] BaseGain   = GainW'(16'h2800);
  localparam logic [AngW-1:0]  TurnZero   = 16'h0000;
  localparam logic [AngW-1:0]  TurnQuart  = 16'h4000;
  localparam logic [AngW-1:0]  TurnHalf   = 16'h8000;
  localparam logic [AngW-1:0]  Turn3Quart = 16'hC000;

  // word carried down the divider chain
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [CompW-1:0] mx;
    logic [TW-1:0]    q;
    logic             axis;      // on an axis: heading fixed
    logic [AngW-1:0]  axis_ang;
    logic             y_pos;
    logic             x_pos;
    logic             x_larger;
  } div_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/atan2_binary_angle.sv @@
// ----------------------------------------------------------------------------
// atan2_binary_angle
// Heading of a signed 2-D vector as a 16-bit binary angle.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  vec_y, vec_x
// out      source     out_valid/ out_stall heading
//
// One word per cycle when not stalled, through one magnitude stage, fifteen
// divider cells (one quotient bit each) and three polynomial stages.
// The whole pipeline halts while a finished word waits on out_stall.
// Reset clears the valid bits only; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_binary_angle (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [a2b_pkg::CompW-1:0] vec_y,
  input  wire logic signed [a2b_pkg::CompW-1:0] vec_x,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [a2b_pkg::AngW-1:0]   heading
);

  localparam int unsigned NCell = a2b_pkg::TW;

  logic                     en;
  logic [a2b_pkg::CompW-1:0] ay, ax;
  a2b_pkg::div_word_t       w0_next;
  a2b_pkg::div_word_t       chain [NCell+1];
  logic                     chain_v [NCell+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    ay = vec_y[a2b_pkg::CompW-1] ? a2b_pkg::CompW'(-vec_y) : vec_y;
    ax = vec_x[a2b_pkg::CompW-1] ? a2b_pkg::CompW'(-vec_x) : vec_x;
    w0_next.x_larger = !(ay > ax);
    w0_next.mx       = w0_next.x_larger ? ax : ay;
    w0_next.rem      = {1'b0, (w0_next.x_larger ? ay : ax)};
    w0_next.q        = '0;
    w0_next.y_pos    = !vec_y[a2b_pkg::CompW-1];
    w0_next.x_pos    = !vec_x[a2b_pkg::CompW-1];
    w0_next.axis     = (vec_y == '0) || (vec_x == '0);
    if (vec_y == '0) begin
      w0_next.axis_ang = (vec_x > 0) ? a2b_pkg::TurnQuart : a2b_pkg::Turn3Quart;
    end else begin
      w0_next.axis_ang = (vec_y > 0) ? a2b_pkg::TurnZero : a2b_pkg::TurnHalf;
    end
    // axis words still go through the divider: keep the divisor nonzero
    if (w0_next.mx == '0) begin
      w0_next.mx = a2b_pkg::CompW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else if (en) begin
      chain_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= w0_next;
    end
  end

  for (genvar i = 0; i < NCell; i++) begin : g_cell
    a2b_div_cell #(.FIRST(i == 0)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .d_valid (chain_v[i]),
      .d       (chain[i]),
      .q_valid (chain_v[i+1]),
      .q       (chain[i+1])
    );
  end

  a2b_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .d_valid   (chain_v[NCell]),
    .d         (chain[NCell]),
    .o_valid   (out_valid),
    .o_heading (heading)
  );

endmodule

`default_nettype wire

@@ hw/rtl/a2b_div_cell.sv @@
// ----------------------------------------------------------------------------
// a2b_div_cell
// One restoring-division cell: produces one quotient bit per word.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_div_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              d_valid,
  input  wire a2b_pkg::div_word_t d,
  output      logic              q_valid,
  output      a2b_pkg::div_word_t q
);

  logic [a2b_pkg::RemW-1:0] trial;
  logic                     ge;
  a2b_pkg::div_word_t       q_next;

  always_comb begin
    trial  = FIRST ? d.rem : {d.rem[a2b_pkg::RemW-2:0], 1'b0};
    ge     = trial >= {1'b0, d.mx};
    q_next = d;
    q_next.rem = ge ? (trial - {1'b0, d.mx}) : trial;
    q_next.q   = {d.q[a2b_pkg::TW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/a2b_post.sv @@
// ----------------------------------------------------------------------------
// a2b_post
// Correction polynomial and octant fold, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_post (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        d_valid,
  input  wire a2b_pkg::div_word_t          d,
  output      logic                        o_valid,
  output      logic [a2b_pkg::AngW-1:0]    o_heading
);

  localparam int unsigned P1W = a2b_pkg::DiffW + a2b_pkg::CorrW;
  localparam int unsigned P2W = a2b_pkg::GainW + a2b_pkg::TW;

  logic [a2b_pkg::DiffW-1:0] diff;
  logic [P1W-1:0]            p1;
  logic [P2W-1:0]            p2;
  logic [a2b_pkg::GainW-1:0] gain;
  logic [a2b_pkg::AngW-1:0]  ang;
  logic [a2b_pkg::AngW-1:0]  heading_next;
  logic [a2b_pkg::TW-1:0]    t1;
  a2b_pkg::div_word_t        w1, w2;
  logic                      v1, v2;

  always_comb begin
    diff = (d.q >= a2b_pkg::KneePoint) ? a2b_pkg::DiffW'(d.q - a2b_pkg::KneePoint)
                                       : a2b_pkg::DiffW'(a2b_pkg::KneePoint - d.q);
    gain = a2b_pkg::BaseGain - a2b_pkg::GainW'(p1[P1W-1:a2b_pkg::RatioSh]);
    ang  = a2b_pkg::AngW'(p2[P2W-1:a2b_pkg::RatioSh]);
    if (w2.axis) begin
      heading_next = w2.axis_ang;
    end else if (w2.y_pos && w2.x_pos) begin
      heading_next = w2.x_larger ? a2b_pkg::TurnQuart - ang : ang;
    end else if (w2.y_pos) begin
      heading_next = w2.x_larger ? a2b_pkg::Turn3Quart + ang : a2b_pkg::TurnZero - ang;
    end else if (w2.x_pos) begin
      heading_next = w2.x_larger ? a2b_pkg::TurnQuart + ang : a2b_pkg::TurnHalf - ang;
    end else begin
      heading_next = w2.x_larger ? a2b_pkg::Turn3Quart - ang : a2b_pkg::TurnHalf + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1      <= d_valid;
      v2      <= v1;
      o_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1        <= P1W'(diff) * P1W'(a2b_pkg::SlopeCorr);
      t1        <= d.q;
      w1        <= d;
      p2        <= P2W'(gain) * P2W'(t1);
      w2        <= w1;
      o_heading <= heading_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/atan2_binary_angle_chk.sv @@
// ----------------------------------------------------------------------------
// atan2_binary_angle_chk
// Port-level checks for the atan2 pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_binary_angle_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] heading
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("word dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(heading))
    else $error("stalled word changed");

  a_stall_src : assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a waiting word");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word present after reset");

endmodule

bind atan2_binary_angle atan2_binary_angle_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .heading   (heading)
);

`default_nettype wire
